### design/gakf_pkg.sv
// ----------------------------------------------------------------------------
// gakf_pkg: shared types and constants of the gyro angle kalman filter
// Fixed-point format, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package gakf_pkg;

  localparam int unsigned FracBits = 20;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CfgW     = 31;
  localparam int unsigned IdxW     = 2;
  localparam int unsigned DivW     = DataW + FracBits + 1;
  localparam int unsigned DivCntW  = $clog2(DivW + 1);

  localparam logic [IdxW-1:0] RegMeasNoise = 2'd0;
  localparam logic [IdxW-1:0] RegAngNoise  = 2'd1;
  localparam logic [IdxW-1:0] RegBiasNoise = 2'd2;
  localparam logic [IdxW-1:0] RegPeriod    = 2'd3;

  localparam logic [CfgW-1:0] MeasNoiseRst = CfgW'((64'd1 << FracBits) / 2);
  localparam logic [CfgW-1:0] AngNoiseRst  = CfgW'(((64'd1 << FracBits) + 5000) / 10000);
  localparam logic [CfgW-1:0] BiasNoiseRst = CfgW'((3 * (64'd1 << FracBits) + 5000) / 10000);
  localparam logic [CfgW-1:0] PeriodRst    = CfgW'(((64'd1 << FracBits) + 500) / 1000);
  localparam logic signed [DataW-1:0] OneQ = DataW'(64'd1 << FracBits);

  typedef logic signed [DataW-1:0] q_t;

  typedef enum logic [4:0] {
    StIdle, StRate, StD0, StMulA, StAddA, StMulP00, StAddP00, StMulP11,
    StAddP01, StMulQb, StAddP11, StErr, StDivStart, StDiv0, StDiv1Start,
    StDiv1, StMulU00, StMulU01, StMulU10, StMulU11, StMulA2, StMulB2, StDone,
    StOut
  } state_e;

  function automatic q_t sat32(input logic signed [DataW+1:0] v);
    if (v > $signed({3'b000, {(DataW-1){1'b1}}})) return {1'b0, {(DataW-1){1'b1}}};
    if (v < $signed({3'b111, {(DataW-1){1'b0}}})) return {1'b1, {(DataW-1){1'b0}}};
    return v[DataW-1:0];
  endfunction

endpackage

### design/gakf_if.sv
// ----------------------------------------------------------------------------
// gakf_if: valid/ready channel carrying two signed q12.20 words
// ----------------------------------------------------------------------------
interface gakf_if;
  logic                      valid;
  logic                      ready;
  logic signed [31:0] a;
  logic signed [31:0] b;
  modport source (output valid, output a, output b, input ready);
  modport sink   (input valid, input a, input b, output ready);
endinterface

### design/gakf_mul.sv
// ----------------------------------------------------------------------------
// gakf_mul: shared fixed-point multiplier
// Registered product, rounded to nearest and saturated to 32 bits.
// ----------------------------------------------------------------------------
module gakf_mul (
  input  logic          clk_i,
  input  gakf_pkg::q_t  a_i,
  input  gakf_pkg::q_t  b_i,
  output gakf_pkg::q_t  p_o
);
  import gakf_pkg::*;
  logic signed [2*DataW-1:0] prod;
  logic signed [2*DataW-1:0] rnd;
  q_t p_q;

  assign prod = a_i * b_i;
  assign rnd  = (prod + (64'sd1 <<< (FracBits - 1))) >>> FracBits;

  always_ff @(posedge clk_i) begin
    if (rnd > 64'sh7fffffff)       p_q <= 32'sh7fffffff;
    else if (rnd < -64'sh80000000) p_q <= 32'sh80000000;
    else                            p_q <= rnd[DataW-1:0];
  end
  assign p_o = p_q;
endmodule

### design/gakf_div.sv
// ----------------------------------------------------------------------------
// gakf_div: radix-2 restoring divider
// Gain = (num << FracBits) / den, truncated and saturated; den > 0.
// ----------------------------------------------------------------------------
module gakf_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  gakf_pkg::q_t                 num_i,
  input  logic [gakf_pkg::DataW:0]     den_i,
  output logic                         done_o,
  output gakf_pkg::q_t                 quo_o
);
  import gakf_pkg::*;
  logic [DivW-1:0]     dvd_q, dvd_d;
  logic [DataW+1:0]    rem_q, rem_d;
  logic [DataW:0]      den_q, den_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic                neg_q, neg_d, busy_q, busy_d;
  logic [DataW+1:0]    trial;
  logic [DivW:0]       mag;

  always_comb begin
    dvd_d = dvd_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    neg_d = neg_q; busy_d = busy_q;
    trial = {rem_q[DataW:0], dvd_q[DivW-1]} - {1'b0, den_q};
    if (start_i) begin
      neg_d  = num_i[DataW-1];
      dvd_d  = {(num_i[DataW-1] ? DataW'(-num_i) : DataW'(num_i)), FracBits'(0)}
               & {DivW{1'b1}};
      if (num_i == {1'b1, {(DataW-1){1'b0}}}) dvd_d = {1'b1, {(DivW-1){1'b0}}} >> 1;
      rem_d  = '0; den_d = den_i; cnt_d = DivCntW'(DivW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DataW+1]) begin
        rem_d = trial; dvd_d = {dvd_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DataW:0], dvd_q[DivW-1]}; dvd_d = {dvd_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d; rem_q <= rem_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign done_o = !busy_q;
  assign mag = {1'b0, dvd_q};
  always_comb begin
    if (!neg_q) quo_o = (mag > (DivW+1)'(32'h7fffffff)) ? 32'sh7fffffff : mag[DataW-1:0];
    else        quo_o = (mag > (DivW+1)'(33'h80000000)) ? 32'sh80000000
                                                        : DataW'(-mag[DataW-1:0]);
  end
endmodule

### design/gyro_angle_kalman_filter.sv
// ----------------------------------------------------------------------------
// gyro_angle_kalman_filter: two-state angle/gyro-bias kalman filter
// One sample per transfer; one result transfer per sample.
// ----------------------------------------------------------------------------
// A sample's time from its transfer to its result is dominated by two
// 53-step divisions on one radix-2 divider, with one state to start the
// second, plus 16 sequencer steps around a single shared registered
// multiplier. When the gain divisor is not positive the divisions are
// skipped. in_ready is high only while the sequencer is idle. The result
// sits in its own output register, so a waiting result does not block the
// next sample; the sequencer stalls in its last step only while a previous
// result is still not taken.
module gyro_angle_kalman_filter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [gakf_pkg::IdxW-1:0]  cfg_idx_i,
  input  logic [gakf_pkg::CfgW-1:0]  cfg_data_i,
  gakf_if.sink                       in_ch,
  gakf_if.source                     out_ch
);
  import gakf_pkg::*;

  logic [CfgW-1:0] r_q, qa_q, qb_q, dt_q;
  q_t ang_q, ang_d, bias_q, bias_d, p00_q, p00_d, p01_q, p01_d;
  q_t p10_q, p10_d, p11_q, p11_d;
  q_t rate_q, rate_d, d0_q, d0_d, err_q, err_d, k0_q, k0_d, k1_q, k1_d;
  q_t z_q, z_d, y0_q, y0_d, y1_q, y1_d;
  q_t oang_q, oang_d, obias_q, obias_d;
  q_t ma, mb, mp, dq;
  logic [DataW:0] e_q, e_d;
  logic ovalid_q, ovalid_d, dstart, ddone;
  state_e st_q, st_d;

  gakf_mul u_mul (.clk_i, .a_i(ma), .b_i(mb), .p_o(mp));
  gakf_div u_div (.clk_i, .rst_ni, .start_i(dstart), .num_i(st_q == StDivStart ? p00_q : p10_q),
                  .den_i(e_q), .done_o(ddone), .quo_o(dq));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= MeasNoiseRst; qa_q <= AngNoiseRst; qb_q <= BiasNoiseRst; dt_q <= PeriodRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMeasNoise: r_q  <= cfg_data_i;
        RegAngNoise:  qa_q <= cfg_data_i;
        RegBiasNoise: qb_q <= cfg_data_i;
        RegPeriod:    dt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ovalid_q <= 1'b0;
      ang_q <= '0; bias_q <= '0; p00_q <= OneQ; p01_q <= '0; p10_q <= '0; p11_q <= OneQ;
    end else begin
      st_q <= st_d; ovalid_q <= ovalid_d;
      ang_q <= ang_d; bias_q <= bias_d; p00_q <= p00_d; p01_q <= p01_d;
      p10_q <= p10_d; p11_q <= p11_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rate_q <= rate_d; d0_q <= d0_d; err_q <= err_d; k0_q <= k0_d; k1_q <= k1_d;
    z_q <= z_d; y0_q <= y0_d; y1_q <= y1_d; e_q <= e_d;
    oang_q <= oang_d; obias_q <= obias_d;
  end

  // multiplier operands chosen per step; the registered product is read in the following step
  always_comb begin
    ma = '0; mb = '0;
    case (st_q)
      StRate:   begin ma = rate_d; mb = q_t'({1'b0, dt_q}); end
      StD0:     begin ma = rate_q; mb = q_t'({1'b0, dt_q}); end
      StMulA:   begin ma = d0_q;   mb = q_t'({1'b0, dt_q}); end
      StAddA:   begin ma = p11_q;  mb = q_t'({1'b0, dt_q}); end
      StMulP00: begin ma = q_t'({1'b0, qb_q}); mb = q_t'({1'b0, dt_q}); end
      StMulU00: begin ma = k0_q; mb = y0_q; end
      StMulU01: begin ma = k0_q; mb = y1_q; end
      StMulU10: begin ma = k1_q; mb = y0_q; end
      StMulU11: begin ma = k1_q; mb = y1_q; end
      StMulA2:  begin ma = k0_q; mb = err_q; end
      StMulB2:  begin ma = k1_q; mb = err_q; end
      default: ;
    endcase
  end

  always_comb begin
    st_d = st_q; ovalid_d = ovalid_q; dstart = 1'b0;
    ang_d = ang_q; bias_d = bias_q; p00_d = p00_q; p01_d = p01_q; p10_d = p10_q;
    p11_d = p11_q; rate_d = rate_q; d0_d = d0_q; err_d = err_q; k0_d = k0_q;
    k1_d = k1_q; z_d = z_q; y0_d = y0_q; y1_d = y1_q; e_d = e_q;
    oang_d = oang_q; obias_d = obias_q;
    if (out_ch.ready) ovalid_d = 1'b0;
    case (st_q)
      StIdle: if (in_ch.valid) begin
        rate_d = sat32((DataW+2)'(in_ch.a) - (DataW+2)'(bias_q));
        z_d = in_ch.b;
        st_d = StRate;
      end
      // rate*dt issued
      StRate: begin
        d0_d = sat32((DataW+2)'($signed({1'b0, qa_q})) - (DataW+2)'(p01_q)
                     - (DataW+2)'(p10_q));
        st_d = StD0;
      end
      StD0: begin
        ang_d = sat32((DataW+2)'(ang_q) + (DataW+2)'(mp)); st_d = StMulA;
      end
      StMulA: st_d = StAddA;   // d0*dt issued here
      StAddA: begin
        p00_d = sat32((DataW+2)'(p00_q) + (DataW+2)'(mp)); st_d = StMulP00;
      end
      StMulP00: begin
        p01_d = sat32((DataW+2)'(p01_q) - (DataW+2)'(mp));
        p10_d = sat32((DataW+2)'(p10_q) - (DataW+2)'(mp));
        st_d = StMulP11;
      end
      StMulP11: begin
        p11_d = sat32((DataW+2)'(p11_q) + (DataW+2)'(mp)); st_d = StErr;
      end
      StErr: begin
        err_d = sat32((DataW+2)'(z_q) - (DataW+2)'(ang_q));
        e_d = (DataW+1)'($signed({2'b0, r_q})) + (DataW+1)'(p00_q);
        st_d = StDivStart;
      end
      StDivStart: begin
        y0_d = p00_q; y1_d = p01_q;
        if (e_q[DataW] || e_q == '0) begin
          k0_d = '0; k1_d = '0; st_d = StMulU00;
        end else begin
          dstart = 1'b1; st_d = StDiv0;
        end
      end
      StDiv0: if (ddone) begin k0_d = dq; st_d = StDiv1Start; end
      StDiv1Start: begin dstart = 1'b1; st_d = StDiv1; end
      StDiv1: if (ddone) begin k1_d = dq; st_d = StMulU00; end
      StMulU00: st_d = StMulU01;
      StMulU01: begin p00_d = sat32((DataW+2)'(p00_q) - (DataW+2)'(mp)); st_d = StMulU10; end
      StMulU10: begin p01_d = sat32((DataW+2)'(p01_q) - (DataW+2)'(mp)); st_d = StMulU11; end
      StMulU11: begin p10_d = sat32((DataW+2)'(p10_q) - (DataW+2)'(mp)); st_d = StMulA2; end
      StMulA2:  begin p11_d = sat32((DataW+2)'(p11_q) - (DataW+2)'(mp)); st_d = StMulB2; end
      StMulB2:  begin ang_d = sat32((DataW+2)'(ang_q) + (DataW+2)'(mp)); st_d = StDone; end
      StDone: begin
        bias_d = sat32((DataW+2)'(bias_q) + (DataW+2)'(mp)); st_d = StOut;
      end
      // hold here while the previous result still waits
      StOut: if (!ovalid_q || out_ch.ready) begin
        oang_d = ang_q; obias_d = bias_q;
        ovalid_d = 1'b1; st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  assign in_ch.ready  = (st_q == StIdle);
  assign out_ch.valid = ovalid_q;
  assign out_ch.a     = oang_q;
  assign out_ch.b     = obias_q;

  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !in_ch.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.a)))
    else $error("result dropped");
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StOut && (!out_ch.valid || out_ch.ready)) |=> out_ch.valid)
    else $error("no result");
endmodule

### sim/gakf_checker.sv
// ----------------------------------------------------------------------------
// gakf_checker: scoreboard of the gyro angle kalman filter
// Mirrors the configuration writes, predicts the filtered angle and bias for
// every accepted sample and compares them with every accepted result.
// ----------------------------------------------------------------------------
module gakf_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [gakf_pkg::IdxW-1:0]  cfg_idx_i,
  input  logic [gakf_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic signed [31:0]         in_rate_i,
  input  logic signed [31:0]         in_angle_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic signed [31:0]         out_angle_i,
  input  logic signed [31:0]         out_bias_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import gakf_pkg::*;

  typedef struct packed {
    q_t angle;
    q_t bias;
  } estimate_t;

  estimate_t pending_estimates[$];

  q_t r_noise, qa_noise, qb_noise, period;
  q_t est_angle, est_bias, p00, p01, p10, p11;

  function automatic q_t clamp(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return q_t'(v);
  endfunction

  // round to nearest, ties upward (arithmetic shift floors)
  function automatic q_t fx_mul(input q_t x, input q_t y);
    longint p;
    p = longint'(x) * longint'(y) + (64'sd1 <<< (FracBits - 1));
    return clamp(p >>> FracBits);
  endfunction

  function automatic q_t fx_div(input q_t n, input longint d);
    longint num;
    num = longint'(n) * (64'sd1 <<< FracBits);
    return clamp(num / d);
  endfunction

  task automatic filter_step(input q_t gyro, input q_t meas);
    q_t rate, d0, err, k0, k1, y0, y1, pd;
    longint e;
    rate = clamp(longint'(gyro) - est_bias);
    d0 = clamp(longint'(qa_noise) - p01 - p10);
    est_angle = clamp(longint'(est_angle) + fx_mul(rate, period));
    pd = fx_mul(p11, period);
    p00 = clamp(longint'(p00) + fx_mul(d0, period));
    p01 = clamp(longint'(p01) - pd);
    p10 = clamp(longint'(p10) - pd);
    p11 = clamp(longint'(p11) + fx_mul(qb_noise, period));
    err = clamp(longint'(meas) - est_angle);
    e = longint'(r_noise) + p00;
    if (e > 0) begin
      k0 = fx_div(p00, e);
      k1 = fx_div(p10, e);
    end else begin
      k0 = '0;
      k1 = '0;
    end
    y0 = p00;
    y1 = p01;
    p00 = clamp(longint'(p00) - fx_mul(k0, y0));
    p01 = clamp(longint'(p01) - fx_mul(k0, y1));
    p10 = clamp(longint'(p10) - fx_mul(k1, y0));
    p11 = clamp(longint'(p11) - fx_mul(k1, y1));
    est_angle = clamp(longint'(est_angle) + fx_mul(k0, err));
    est_bias = clamp(longint'(est_bias) + fx_mul(k1, err));
    pending_estimates.push_back('{est_angle, est_bias});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    estimate_t exp_est;
    if (!rst_ni) begin
      r_noise   <= q_t'(MeasNoiseRst);
      qa_noise  <= q_t'(AngNoiseRst);
      qb_noise  <= q_t'(BiasNoiseRst);
      period    <= q_t'(PeriodRst);
      est_angle <= '0;
      est_bias  <= '0;
      p00       <= OneQ;
      p01       <= '0;
      p10       <= '0;
      p11       <= OneQ;
      pending_estimates.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegMeasNoise: r_noise  = q_t'({1'b0, cfg_data_i});
          RegAngNoise:  qa_noise = q_t'({1'b0, cfg_data_i});
          RegBiasNoise: qb_noise = q_t'({1'b0, cfg_data_i});
          RegPeriod:    period   = q_t'({1'b0, cfg_data_i});
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_estimates.size() == 0) begin
          $display("%0t: unexpected result angle=%0d bias=%0d",
                   $time, out_angle_i, out_bias_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_est = pending_estimates.pop_front();
          if (exp_est.angle !== out_angle_i || exp_est.bias !== out_bias_i) begin
            $display("%0t: mismatch expected angle=%0d bias=%0d actual angle=%0d bias=%0d",
                     $time, exp_est.angle, exp_est.bias, out_angle_i, out_bias_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) filter_step(in_rate_i, in_angle_i);
      pending_o <= pending_estimates.size();
    end
  end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top of the gyro angle kalman filter bench
// Drives samples with random gaps and result stalls, walks through several
// noise and period settings, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module testbench;
  import gakf_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  int fail_count, pending;
  bit stall_enable = 1'b1;

  gakf_if in_ch ();
  gakf_if out_ch ();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.a = '0;
    in_ch.b = '0;
    out_ch.ready = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  gyro_angle_kalman_filter DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  gakf_checker scoreboard (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready),
    .in_rate_i(in_ch.a), .in_angle_i(in_ch.b), .out_valid_i(out_ch.valid),
    .out_ready_i(out_ch.ready), .out_angle_i(out_ch.a), .out_bias_i(out_ch.b),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // result side: random stall before each transfer
  always begin
    int gap;
    @(posedge clk_i);
    if (rst_ni) begin
      gap = stall_enable ? $urandom_range(0, 5) : 0;
      repeat (gap) @(posedge clk_i);
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      out_ch.ready <= 1'b0;
    end
  end

  // valid stays high into the next call unless a gap is drawn
  task automatic send_sample(input logic signed [31:0] rate,
                             input logic signed [31:0] angle, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.a <= rate;
    in_ch.b <= angle;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic drain();
    wait_idle();
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [CfgW-1:0] r, input logic [CfgW-1:0] qa,
                            input logic [CfgW-1:0] qb, input logic [CfgW-1:0] dt);
    write_reg(RegMeasNoise, r);
    write_reg(RegAngNoise, qa);
    write_reg(RegBiasNoise, qb);
    write_reg(RegPeriod, dt);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_word(input int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 2 * 1048576)) - 1048576;
      default: return $signed($urandom_range(0, 200 * 1048576)) - 100 * 1048576;
    endcase
  endfunction

  initial begin
    logic signed [31:0] corners[6];
    int phase;
    corners = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1, 32'sh00100000};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed extremes with reset settings
    foreach (corners[i]) send_sample(corners[i], corners[(i + 3) % 6], 1'b1);
    send_sample(32'sh7fffffff, 32'sh7fffffff, 1'b0);
    send_sample(32'sh80000000, 32'sh80000000, 1'b0);
    drain();
    // extreme registers: zero measurement noise, max process noise and period
    set_config('0, '1, '1, '1);
    for (int i = 0; i < 8; i++) send_sample(corners[i % 6], corners[(i * 5) % 6], 1'b1);
    drain();
    set_config('1, '0, '0, 31'd1);
    for (int i = 0; i < 6; i++) send_sample(corners[i], corners[5 - i], 1'b0);
    drain();
    // random phases; the last one restores the reset settings
    for (phase = 0; phase < 8; phase++) begin
      if (phase == 7) begin
        set_config(MeasNoiseRst, AngNoiseRst, BiasNoiseRst, PeriodRst);
      end else begin
        set_config(phase[0] ? CfgW'($urandom()) : CfgW'($urandom_range(0, 1 << 21)),
                   phase[1] ? CfgW'($urandom()) : CfgW'($urandom_range(0, 4096)),
                   phase[1] ? CfgW'($urandom()) : CfgW'($urandom_range(0, 4096)),
                   phase[2] ? CfgW'($urandom()) : CfgW'($urandom_range(1, 1 << 17)));
      end
      stall_enable = (phase != 3);
      for (int i = 0; i < 200; i++) begin
        if (i == 100) wait_idle();
        send_sample(rand_word($urandom_range(0, 2)), rand_word($urandom_range(0, 2)),
                    phase != 3);
      end
      drain();
    end
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
